/* sv/vrp_pkg.sv */
// Shared types, constants and arithmetic helpers of the vertex rotate/project block.
// No dependencies; every other file imports this package.
package vrp_pkg;

    localparam int WINDOW_WIDTH  = 1920;
    localparam int WINDOW_HEIGHT = 1080;
    localparam int MENU_WIDTH    = 256;

    localparam logic [2:0] REG_ZOOM    = 3'd0;
    localparam logic [2:0] REG_Z_SCALE = 3'd1;
    localparam logic [2:0] REG_ANGLE_X = 3'd2;
    localparam logic [2:0] REG_ANGLE_Y = 3'd3;
    localparam logic [2:0] REG_ANGLE_Z = 3'd4;
    localparam logic [2:0] REG_ISO     = 3'd5;
    localparam logic [2:0] REG_MAP     = 3'd6;
    localparam logic [2:0] REG_PAN     = 3'd7;

    localparam int CW = 28;
    localparam logic signed [47:0] COS30_Q15 = 48'sd28378;
    localparam logic signed [33:0] X_CENTRE =
        34'((WINDOW_WIDTH - MENU_WIDTH) / 2 + MENU_WIDTH);
    localparam logic [24:0] Y_WINDOW = 25'(WINDOW_HEIGHT);

    localparam logic [15:0] QSIN [0:64] = '{
        16'd0,     16'd804,   16'd1608,  16'd2411,  16'd3212,  16'd4011,  16'd4808,  16'd5602,
        16'd6393,  16'd7179,  16'd7962,  16'd8740,  16'd9512,  16'd10279, 16'd11039, 16'd11793,
        16'd12540, 16'd13279, 16'd14010, 16'd14733, 16'd15447, 16'd16151, 16'd16846, 16'd17531,
        16'd18205, 16'd18868, 16'd19520, 16'd20160, 16'd20788, 16'd21403, 16'd22006, 16'd22595,
        16'd23170, 16'd23732, 16'd24279, 16'd24812, 16'd25330, 16'd25833, 16'd26320, 16'd26791,
        16'd27246, 16'd27684, 16'd28106, 16'd28511, 16'd28899, 16'd29269, 16'd29622, 16'd29957,
        16'd30274, 16'd30572, 16'd30853, 16'd31114, 16'd31357, 16'd31581, 16'd31786, 16'd31972,
        16'd32138, 16'd32286, 16'd32413, 16'd32522, 16'd32610, 16'd32679, 16'd32729, 16'd32758,
        16'd32767
    };

    typedef logic signed [CW-1:0] t_coord;

    typedef struct packed {
        logic [11:0]        column;
        logic [11:0]        row;
        logic signed [15:0] height;
        logic [23:0]        color;
    } t_in;

    typedef struct packed {
        logic signed [15:0] screen_x;
        logic signed [15:0] screen_y;
        logic signed [15:0] depth;
        logic [23:0]        color_out;
    } t_out;

    typedef struct packed {
        logic [7:0]  zoom;
        logic [15:0] z_scale;
        logic [15:0] angle_x;
        logic [15:0] angle_y;
        logic [15:0] angle_z;
        logic        iso_mode;
        logic [31:0] map_size;
        logic [31:0] pan;
    } t_cfg;

    typedef struct packed {
        t_coord      x;
        t_coord      y;
        t_coord      z;
        logic [23:0] color;
    } t_mid;

    function automatic logic signed [15:0] phase_sin(input logic [15:0] p);
        logic [14:0]        m;
        logic [5:0]         t;
        logic signed [16:0] d;
        logic signed [25:0] df;
        logic signed [15:0] v;
        m = {1'b0, p[13:0]};
        if (p[14]) begin
            m = 15'd16384 - m;
        end
        t = m[13:8];
        d = $signed({1'b0, QSIN[7'(t) + 7'd1]}) - $signed({1'b0, QSIN[{1'b0, t}]});
        df = 26'(d) * 26'($signed({1'b0, m[7:0]}));
        if (m[14]) begin
            v = 16'sd32767;
        end else begin
            v = $signed(QSIN[{1'b0, t}]) + 16'(df >>> 8);
        end
        if (p[15]) begin
            v = -v;
        end
        return v;
    endfunction

    function automatic logic signed [47:0] mulq(input t_coord a, input logic signed [15:0] b);
        return 48'(a) * 48'(b);
    endfunction

    function automatic logic signed [32:0] div15(input logic signed [47:0] v);
        logic signed [47:0] a;
        a = v + (v[47] ? 48'sd32767 : 48'sd0);
        return 33'(a >>> 15);
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [33:0] v);
        logic signed [15:0] r;
        if (v > 34'sd32767) begin
            r = 16'sh7fff;
        end else if (v < -34'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

/* sv/vrp_front.sv */
// Input stage: accepts vertices, applies zoom, height scale and map centring.
// Depends on vrp_pkg.
module vrp_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  vrp_pkg::t_cfg i_cfg,
    input  logic          i_push,
    output logic          o_full,
    input  vrp_pkg::t_in  i_item,
    output logic          o_q_push,
    input  logic          i_q_full,
    output vrp_pkg::t_mid o_q_data
);
    import vrp_pkg::*;

    logic        r_fv;
    logic        n_fv;
    t_mid        r_word;
    t_mid        n_word;
    logic        accept;
    logic [19:0] x_mul;
    logic [19:0] y_mul;
    logic [23:0] w_mul;
    logic [23:0] h_mul;
    logic signed [32:0] z_mul;
    logic signed [32:0] z_adj;

    assign o_full   = r_fv && i_q_full;
    assign accept   = i_push && !o_full;
    assign o_q_push = r_fv && !i_q_full;
    assign o_q_data = r_word;

    always_comb begin
        x_mul = 20'(i_item.column) * 20'(i_cfg.zoom);
        y_mul = 20'(i_item.row) * 20'(i_cfg.zoom);
        w_mul = 24'(i_cfg.map_size[15:0]) * 24'(i_cfg.zoom);
        h_mul = 24'(i_cfg.map_size[31:16]) * 24'(i_cfg.zoom);
        z_mul = 33'(i_item.height) * 33'($signed({1'b0, i_cfg.z_scale}));
        z_adj = z_mul + (z_mul[32] ? 33'sd255 : 33'sd0);
        n_word.x     = $signed({8'b0, x_mul}) - $signed({5'b0, w_mul[23:1]});
        n_word.y     = $signed({8'b0, y_mul}) - $signed({5'b0, h_mul[23:1]});
        n_word.z     = CW'(z_adj >>> 8);
        n_word.color = i_item.color;
        if (accept) begin
            n_fv = 1'b1;
        end else if (o_q_push) begin
            n_fv = 1'b0;
        end else begin
            n_fv = r_fv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
        end else begin
            r_fv <= n_fv;
        end
        if (accept) begin
            r_word <= n_word;
        end
    end

endmodule

/* sv/vrp_queue.sv */
// Four-word queue between the input stage and the rotation pipeline.
// Depends on vrp_pkg.
module vrp_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  vrp_pkg::t_mid i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output vrp_pkg::t_mid o_data
);
    import vrp_pkg::*;

    t_mid       r_mem [0:3];
    logic [1:0] r_wr;
    logic [1:0] r_rd;
    logic [2:0] r_cnt;
    logic       do_push;
    logic       do_pop;

    assign o_full  = r_cnt == 3'd4;
    assign o_empty = r_cnt == 3'd0;
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 2'd0;
            r_rd  <= 2'd0;
            r_cnt <= 3'd0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 2'd1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 2'd1;
            end
            r_cnt <= r_cnt + 3'(do_push) - 3'(do_pop);
        end
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

/* sv/vrp_back.sv */
// Rotation pipeline: x, y and z rotations, isometric step when iso_mode is set, offsets and saturation.
// Depends on vrp_pkg.
module vrp_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  vrp_pkg::t_cfg i_cfg,
    input  logic          i_q_empty,
    input  vrp_pkg::t_mid i_q_data,
    output logic          o_q_pop,
    output logic          o_empty,
    input  logic          i_pop,
    output vrp_pkg::t_out o_word
);
    import vrp_pkg::*;

    logic signed [15:0] r_sx, r_cx, r_sy, r_cy, r_sz, r_cz;
    logic [4:0]         r_v;
    t_mid               r_s0, r_s1, r_s2;
    t_coord             r_x3, r_y3, r_z3;
    logic signed [15:0] r_d3;
    logic [23:0]        r_c3;
    t_out               r_out;
    logic               en;

    t_coord             x3, y3, x2, z2, y1, z1;
    logic signed [28:0] dxy, sxy;
    logic signed [32:0] xq, yq;
    logic signed [33:0] xf, yf;
    logic [23:0]        h_mul;
    logic [24:0]        y_cen;

    assign en      = !r_v[4] || i_pop;
    assign o_q_pop = en && !i_q_empty;
    assign o_empty = !r_v[4];
    assign o_word  = r_out;

    always_comb begin
        y1 = CW'(div15(mulq(r_s0.y, r_cx) + mulq(r_s0.z, r_sx)));
        z1 = CW'(div15(mulq(r_s0.z, r_cx) - mulq(r_s0.y, r_sx)));
        x2 = CW'(div15(mulq(r_s1.x, r_cy) + mulq(r_s1.z, r_sy)));
        z2 = CW'(div15(mulq(r_s1.z, r_cy) - mulq(r_s1.x, r_sy)));
        x3 = CW'(div15(mulq(r_s2.x, r_cz) - mulq(r_s2.y, r_sz)));
        y3 = CW'(div15(mulq(r_s2.x, r_sz) + mulq(r_s2.y, r_cz)));
        dxy = 29'(r_x3) - 29'(r_y3);
        sxy = 29'(r_x3) + 29'(r_y3);
        if (i_cfg.iso_mode) begin
            xq = div15(48'(dxy) * COS30_Q15);
            yq = div15(-(48'(r_z3) <<< 15) + (48'(sxy) <<< 14));
        end else begin
            xq = 33'(r_x3);
            yq = 33'(r_y3);
        end
        h_mul = 24'(i_cfg.map_size[31:16]) * 24'(i_cfg.zoom);
        y_cen = Y_WINDOW + 25'(h_mul);
        xf = 34'(xq) + X_CENTRE + 34'($signed(i_cfg.pan[15:0]));
        yf = 34'(yq) + $signed({10'b0, y_cen[24:1]}) + 34'($signed(i_cfg.pan[31:16]));
    end

    always_ff @(posedge i_clk) begin
        r_sx <= phase_sin(i_cfg.angle_x);
        r_cx <= phase_sin(i_cfg.angle_x + 16'd16384);
        r_sy <= phase_sin(i_cfg.angle_y);
        r_cy <= phase_sin(i_cfg.angle_y + 16'd16384);
        r_sz <= phase_sin(i_cfg.angle_z);
        r_cz <= phase_sin(i_cfg.angle_z + 16'd16384);
        if (!i_rst_n) begin
            r_v <= 5'd0;
        end else if (en) begin
            r_v <= {r_v[3:0], !i_q_empty};
        end
        if (en) begin
            r_s0 <= i_q_data;
            r_s1 <= '{x: r_s0.x, y: y1, z: z1, color: r_s0.color};
            r_s2 <= '{x: x2, y: r_s1.y, z: z2, color: r_s1.color};
            r_x3 <= x3;
            r_y3 <= y3;
            r_z3 <= r_s2.z;
            r_d3 <= sat16(34'(r_s2.z));
            r_c3 <= r_s2.color;
            r_out.screen_x  <= sat16(xf);
            r_out.screen_y  <= sat16(yf);
            r_out.depth     <= r_d3;
            r_out.color_out <= r_c3;
        end
    end

endmodule

/* sv/vertex_rotate_project_core.sv */
// Top level of the vertex rotate/project block: configuration registers and wiring.
// Depends on vrp_pkg, vrp_front, vrp_queue and vrp_back.
//
//   word     direction  handshake         payload
//   vertex   in         i_push / o_full   i_item  (column, row, height, color)
//   screen   out        o_empty / i_pop   o_word  (screen_x, screen_y, depth, color_out)
//   config   in         i_cfg_we          i_cfg_addr, i_cfg_wdata
//
// One vertex per cycle unless the output stalls; o_empty falls as it reaches r_out.
// Sine and cosine are registered from the angle registers in the cycle after a write.
// Reset is synchronous and clears control state and configuration to defaults.
// A four-word queue lets the input stage keep accepting while the output stalls, until it fills.
module vertex_rotate_project_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    output logic          o_full,
    input  vrp_pkg::t_in  i_item,
    output logic          o_empty,
    input  logic          i_pop,
    output vrp_pkg::t_out o_word,
    input  logic          i_cfg_we,
    input  logic [2:0]    i_cfg_addr,
    input  logic [31:0]   i_cfg_wdata
);
    import vrp_pkg::*;

    t_cfg r_cfg;
    t_mid q_in, q_out;
    logic q_push, q_full, q_pop, q_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{zoom: 8'd20, z_scale: 16'd256, angle_x: 16'd0, angle_y: 16'd0,
                       angle_z: 16'd0, iso_mode: 1'b1, map_size: 32'd0, pan: 32'd0};
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_ZOOM:    r_cfg.zoom     <= i_cfg_wdata[7:0];
                REG_Z_SCALE: r_cfg.z_scale  <= i_cfg_wdata[15:0];
                REG_ANGLE_X: r_cfg.angle_x  <= i_cfg_wdata[15:0];
                REG_ANGLE_Y: r_cfg.angle_y  <= i_cfg_wdata[15:0];
                REG_ANGLE_Z: r_cfg.angle_z  <= i_cfg_wdata[15:0];
                REG_ISO:     r_cfg.iso_mode <= i_cfg_wdata[0];
                REG_MAP:     r_cfg.map_size <= i_cfg_wdata;
                REG_PAN:     r_cfg.pan      <= i_cfg_wdata;
                default:     r_cfg          <= r_cfg;
            endcase
        end
    end

    vrp_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_push   (i_push),
        .o_full   (o_full),
        .i_item   (i_item),
        .o_q_push (q_push),
        .i_q_full (q_full),
        .o_q_data (q_in)
    );

    vrp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_out)
    );

    vrp_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_empty (q_empty),
        .i_q_data  (q_out),
        .o_q_pop   (q_pop),
        .o_empty   (o_empty),
        .i_pop     (i_pop),
        .o_word    (o_word)
    );

endmodule
